[design/assert_macros.svh]
// Assertion macros shared by the tone generator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define STG_ASSERT_HOLDS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Same-cycle implication.
`define STG_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define STG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/stg_pkg.sv]
// Types and constants shared by the square-wave tone generator.
package stg_pkg;

    localparam int PIN_W      = 8;
    localparam int FREQ_W     = 16;
    localparam int DUR_W      = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int PEXP_W     = 4;
    localparam int CMPOUT_W   = 16;
    localparam int DIV_W      = 32;
    localparam int DVS_W      = 16;
    localparam int DIV_CNT_W  = 5;

    // x / 1000 == (x * MS_RECIP) >> MS_RECIP_SHIFT for any 32-bit x
    localparam int RECIP_W        = 29;
    localparam int MS_RECIP_SHIFT = 38;

    localparam logic [PIN_W-1:0]   NO_OWNER   = 8'hFF;
    localparam logic [FREQ_W-1:0]  FREQ_RESET = 16'd1000;
    localparam logic [RECIP_W-1:0] MS_RECIP   = 29'd274877907;
    localparam logic [DUR_W-1:0]   UNLIMITED  = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_NOP   = 2'd3
    } stg_op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FREQ     = 1'd0,
        CFG_DURATION = 1'd1
    } stg_cfg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HALF_DIV,
        S_SEARCH,
        S_BUDGET
    } stg_state_t;

    typedef struct packed {
        stg_op_t           operation;
        logic [PIN_W-1:0]  pin_number;
    } stg_in_t;

    typedef struct packed {
        logic                tone_level;
        logic                tone_active;
        logic [PEXP_W-1:0]   prescale_exp;
        logic [CMPOUT_W-1:0] compare_value;
    } stg_out_t;

    typedef struct packed {
        logic item_accept;
        logic load_start;
        logic capture_half;
        logic search_step;
        logic budget_start;
        logic commit;
    } stg_cmd_t;

    typedef struct packed {
        logic div_done;
        logic search_done;
        logic result_full;
    } stg_status_t;

endpackage

[design/stg_divider.sv]
// Restoring divider, one quotient bit per cycle.
module stg_divider
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [stg_pkg::DIV_W-1:0]     dividend,
    input  logic [stg_pkg::DVS_W-1:0]     divisor,
    output logic                          done,
    output logic [stg_pkg::DIV_W-1:0]     quotient
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [stg_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [stg_pkg::DVS_W-1:0]      rem_reg, rem_next;
    logic [stg_pkg::DIV_W-1:0]      quo_reg, quo_next;
    logic [stg_pkg::DVS_W-1:0]      dvs_reg, dvs_next;
    logic [stg_pkg::DVS_W:0]        shifted;
    logic [stg_pkg::DVS_W:0]        diff;
    logic                           ge;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[stg_pkg::DIV_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        ge        = (shifted >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[stg_pkg::DVS_W-1:0] : shifted[stg_pkg::DVS_W-1:0];
            quo_next = {quo_reg[stg_pkg::DIV_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == stg_pkg::DIV_CNT_W'(stg_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[design/stg_ctrl.sv]
// Controller state machine for transaction acceptance and the start sequence.
`include "assert_macros.svh"

module stg_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  stg_pkg::stg_op_t      operation,
    input  stg_pkg::stg_status_t  status,
    output logic                  item_stall,
    output stg_pkg::stg_cmd_t     cmd
);

    stg_pkg::stg_state_t state_reg, state_next;
    logic                accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stg_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        item_stall = (state_reg != stg_pkg::S_IDLE) || status.result_full;
        accept     = item_valid && !item_stall;
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            stg_pkg::S_IDLE:
            begin
                cmd.item_accept = accept;
                if (accept && (operation == stg_pkg::OP_START))
                begin
                    cmd.load_start = 1'b1;
                    state_next     = stg_pkg::S_HALF_DIV;
                end
            end
            stg_pkg::S_HALF_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.capture_half = 1'b1;
                    state_next       = stg_pkg::S_SEARCH;
                end
            end
            stg_pkg::S_SEARCH:
            begin
                cmd.search_step = 1'b1;
                if (status.search_done)
                begin
                    cmd.budget_start = 1'b1;
                    state_next       = stg_pkg::S_BUDGET;
                end
            end
            stg_pkg::S_BUDGET:
            begin
                cmd.commit = 1'b1;
                state_next = stg_pkg::S_IDLE;
            end
            default:
            begin
                state_next = stg_pkg::S_IDLE;
            end
        endcase
    end

    `STG_ASSERT_IMPLY(a_busy_stalls, clk, rst_n, state_reg != stg_pkg::S_IDLE, item_stall)
    `STG_ASSERT_NEXT(a_start_divides, clk, rst_n, cmd.load_start, state_reg == stg_pkg::S_HALF_DIV)

endmodule

[design/stg_datapath.sv]
// Datapath: config registers, tone state, start arithmetic and result buffer.
`include "assert_macros.svh"

module stg_datapath
#(
    parameter int BASE_CLOCK_HZ    = 16000000,
    parameter int MAX_PRESCALE_EXP = 9,
    parameter int COMPARE_BITS     = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  stg_pkg::stg_in_t                   item,
    input  logic                               cfg_write_en,
    input  logic [stg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [stg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  stg_pkg::stg_cmd_t                  cmd,
    output stg_pkg::stg_status_t               status,
    output logic                               result_valid,
    input  logic                               result_stall,
    output stg_pkg::stg_out_t                  result
);

    localparam int PS_W = MAX_PRESCALE_EXP;
    localparam logic [stg_pkg::DIV_W-1:0] BASE_HZ = stg_pkg::DIV_W'(BASE_CLOCK_HZ);
    localparam logic [stg_pkg::DIV_W-1:0] CMP_MASK =
        stg_pkg::DIV_W'((64'd1 << COMPARE_BITS) - 64'd1);
    localparam logic [stg_pkg::PEXP_W-1:0] LAST_EXP = stg_pkg::PEXP_W'(MAX_PRESCALE_EXP);

    // configuration
    logic [stg_pkg::FREQ_W-1:0] freq_reg;
    logic [stg_pkg::DUR_W-1:0]  dur_reg;

    // tone state
    logic [stg_pkg::PIN_W-1:0]  owner_reg, owner_next;
    logic                       running_reg, running_next;
    logic                       limited_reg, limited_next;
    logic [stg_pkg::DUR_W-1:0]  toggles_reg, toggles_next;
    logic [PS_W-1:0]            ps_cnt_reg, ps_cnt_next;
    logic [COMPARE_BITS-1:0]    timer_reg, timer_next;
    logic [COMPARE_BITS-1:0]    compare_reg, compare_next;
    logic [stg_pkg::PEXP_W-1:0] prescale_reg, prescale_next;
    logic                       level_reg, level_next;

    // start sequence
    logic [stg_pkg::PIN_W-1:0]  pin_reg;
    logic [stg_pkg::DIV_W-1:0]  half_reg;
    logic [stg_pkg::DUR_W-1:0]  prod_reg;
    logic [stg_pkg::PEXP_W-1:0] k_reg;
    logic [stg_pkg::PEXP_W-1:0] pend_p_reg;
    logic [COMPARE_BITS-1:0]    pend_c_reg;
    logic [stg_pkg::FREQ_W-1:0] freq_eff;
    logic [stg_pkg::DIV_W-1:0]  cand;
    logic                       fits;

    // budget
    logic [stg_pkg::DUR_W-1:0]                  budget_x;
    logic [stg_pkg::DUR_W+stg_pkg::RECIP_W-1:0] budget_prod;
    logic [stg_pkg::DUR_W-1:0]                  budget_reg;

    // divider
    logic                       div_start;
    logic [stg_pkg::DIV_W-1:0]  div_dividend;
    logic [stg_pkg::DVS_W-1:0]  div_divisor;
    logic                       div_done;
    logic [stg_pkg::DIV_W-1:0]  div_quo;

    // tick helpers
    logic [PS_W:0]              ps_one;
    logic [PS_W-1:0]            ps_last;

    // result buffer
    stg_pkg::stg_out_t          res_new;
    stg_pkg::stg_out_t          head_reg, tail_reg;
    logic                       head_valid_reg, tail_valid_reg;
    logic                       push, pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg <= stg_pkg::FREQ_RESET;
            dur_reg  <= '0;
        end
        else if (cfg_write_en)
        begin
            if (cfg_index == stg_pkg::CFG_FREQ)
            begin
                freq_reg <= cfg_data[stg_pkg::FREQ_W-1:0];
            end
            else if (cfg_index == stg_pkg::CFG_DURATION)
            begin
                dur_reg <= cfg_data[stg_pkg::DUR_W-1:0];
            end
        end
    end

    assign freq_eff     = (freq_reg != '0) ? freq_reg : stg_pkg::FREQ_W'(1);
    assign div_start    = cmd.load_start;
    assign div_dividend = BASE_HZ;
    assign div_divisor  = freq_eff;

    stg_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign cand = (half_reg >> ({1'b0, k_reg} + 5'd1)) - stg_pkg::DIV_W'(1);
    assign fits = (cand >= stg_pkg::DIV_W'(2)) && (cand <= CMP_MASK);

    // 2 * freq * duration wraps at 32 bits, then divided by 1000
    assign budget_x    = {prod_reg[stg_pkg::DUR_W-2:0], 1'b0};
    assign budget_prod = budget_x * stg_pkg::MS_RECIP;

    assign status.div_done    = div_done;
    assign status.search_done = fits || (k_reg == LAST_EXP);
    assign status.result_full = tail_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_start)
        begin
            pin_reg  <= item.pin_number;
            prod_reg <= stg_pkg::DUR_W'(freq_eff * dur_reg);
        end
        if (cmd.capture_half)
        begin
            half_reg <= div_quo;
            k_reg    <= '0;
        end
        else if (cmd.search_step)
        begin
            k_reg <= k_reg + 1'b1;
        end
        if (cmd.search_step && status.search_done)
        begin
            pend_p_reg <= k_reg;
            pend_c_reg <= COMPARE_BITS'(cand);
        end
        if (cmd.budget_start)
        begin
            budget_reg <= stg_pkg::DUR_W'(budget_prod >> stg_pkg::MS_RECIP_SHIFT);
        end
    end

    always_comb
    begin
        ps_one        = (PS_W+1)'(1) << prescale_reg;
        ps_last       = PS_W'(ps_one - 1'b1);
        owner_next    = owner_reg;
        running_next  = running_reg;
        limited_next  = limited_reg;
        toggles_next  = toggles_reg;
        ps_cnt_next   = ps_cnt_reg;
        timer_next    = timer_reg;
        compare_next  = compare_reg;
        prescale_next = prescale_reg;
        level_next    = level_reg;
        if (cmd.commit)
        begin
            owner_next    = pin_reg;
            prescale_next = pend_p_reg;
            compare_next  = pend_c_reg;
            if (dur_reg != '0)
            begin
                limited_next = 1'b1;
                toggles_next = (budget_reg == '0) ? stg_pkg::DUR_W'(1) : budget_reg;
            end
            else
            begin
                limited_next = 1'b0;
                toggles_next = stg_pkg::UNLIMITED;
            end
            level_next   = 1'b0;
            ps_cnt_next  = '0;
            timer_next   = '0;
            running_next = 1'b1;
        end
        else if (cmd.item_accept)
        begin
            case (item.operation)
                stg_pkg::OP_TICK:
                begin
                    if (running_reg)
                    begin
                        if (ps_cnt_reg < ps_last)
                        begin
                            ps_cnt_next = ps_cnt_reg + 1'b1;
                        end
                        else
                        begin
                            ps_cnt_next = '0;
                            if (timer_reg != compare_reg)
                            begin
                                timer_next = timer_reg + 1'b1;
                            end
                            else
                            begin
                                timer_next = '0;
                                level_next = !level_reg;
                                if (limited_reg)
                                begin
                                    if (toggles_reg != '0)
                                    begin
                                        toggles_next = toggles_reg - 1'b1;
                                    end
                                    else
                                    begin
                                        running_next = 1'b0;
                                        limited_next = 1'b0;
                                        toggles_next = '0;
                                        owner_next   = stg_pkg::NO_OWNER;
                                        level_next   = 1'b0;
                                        ps_cnt_next  = '0;
                                        timer_next   = '0;
                                    end
                                end
                            end
                        end
                    end
                end
                stg_pkg::OP_STOP:
                begin
                    if (item.pin_number == owner_reg)
                    begin
                        running_next = 1'b0;
                        limited_next = 1'b0;
                        toggles_next = '0;
                        owner_next   = stg_pkg::NO_OWNER;
                        level_next   = 1'b0;
                        ps_cnt_next  = '0;
                        timer_next   = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_reg    <= stg_pkg::NO_OWNER;
            running_reg  <= 1'b0;
            limited_reg  <= 1'b0;
            toggles_reg  <= '0;
            ps_cnt_reg   <= '0;
            timer_reg    <= '0;
            compare_reg  <= '0;
            prescale_reg <= '0;
            level_reg    <= 1'b0;
        end
        else
        begin
            owner_reg    <= owner_next;
            running_reg  <= running_next;
            limited_reg  <= limited_next;
            toggles_reg  <= toggles_next;
            ps_cnt_reg   <= ps_cnt_next;
            timer_reg    <= timer_next;
            compare_reg  <= compare_next;
            prescale_reg <= prescale_next;
            level_reg    <= level_next;
        end
    end

    // result of the transaction, taken from the updated state
    always_comb
    begin
        res_new.tone_level    = running_next && level_next;
        res_new.tone_active   = running_next;
        res_new.prescale_exp  = prescale_next;
        res_new.compare_value = stg_pkg::CMPOUT_W'(compare_next);
    end

    assign push = cmd.commit || (cmd.item_accept && (item.operation != stg_pkg::OP_START));
    assign pop  = head_valid_reg && !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (tail_valid_reg)
            begin
                head_valid_reg <= 1'b1;
                tail_valid_reg <= push;
            end
            else
            begin
                head_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (!head_valid_reg)
            begin
                head_valid_reg <= 1'b1;
            end
            else
            begin
                tail_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (tail_valid_reg)
            begin
                head_reg <= tail_reg;
                if (push)
                begin
                    tail_reg <= res_new;
                end
            end
            else if (push)
            begin
                head_reg <= res_new;
            end
        end
        else if (push)
        begin
            if (!head_valid_reg)
            begin
                head_reg <= res_new;
            end
            else
            begin
                tail_reg <= res_new;
            end
        end
    end

    assign result_valid = head_valid_reg;
    assign result       = head_reg;

    `STG_ASSERT_IMPLY(a_tail_needs_head, clk, rst_n, tail_valid_reg, head_valid_reg)
    `STG_ASSERT_IMPLY(a_idle_quiet, clk, rst_n, !running_reg, !level_reg && (toggles_reg == '0))
    `STG_ASSERT_IMPLY(a_unlimited_budget, clk, rst_n, running_reg && !limited_reg, toggles_reg == stg_pkg::UNLIMITED)

endmodule

[design/square_wave_tone_generator.sv]
// Top level: square-wave tone generator, controller plus datapath.
// Tick, stop, no-op: result registered into the result buffer on acceptance, one per cycle sustained while
// the result buffer is not full. Start: result registered after the states S_HALF_DIV, S_SEARCH and S_BUDGET:
// a serial divide (base clock / freq), a 1-per-cycle prescaler scan, then the budget and commit step.
// Input stalls during a start and when both result buffer entries are full.
// Async active-low reset: tone idle, no owner, frequency 1000 Hz, duration 0.
module square_wave_tone_generator
#(
    parameter int BASE_CLOCK_HZ    = 16000000,
    parameter int MAX_PRESCALE_EXP = 9,
    parameter int COMPARE_BITS     = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  stg_pkg::stg_in_t                   item,
    output logic                               result_valid,
    input  logic                               result_stall,
    output stg_pkg::stg_out_t                  result,
    input  logic                               cfg_write_en,
    input  logic [stg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [stg_pkg::CFG_DATA_W-1:0]     cfg_data
);

    stg_pkg::stg_cmd_t    cmd;
    stg_pkg::stg_status_t status;

    stg_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .operation  (item.operation),
        .status     (status),
        .item_stall (item_stall),
        .cmd        (cmd)
    );

    stg_datapath
    #(
        .BASE_CLOCK_HZ    (BASE_CLOCK_HZ),
        .MAX_PRESCALE_EXP (MAX_PRESCALE_EXP),
        .COMPARE_BITS     (COMPARE_BITS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
